FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CHK_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/msbbp_pkg.sv
// ----------------------------------------------------------------------------
// msbbp_pkg
// Types and constants shared by the MSB-first bit packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msbbp_pkg;

   localparam int MAX_FIELD_BITS = 32;
   localparam int FIELD_W        = 32;
   localparam int COUNT_W        = 6;
   localparam int BYTE_W         = 8;
   localparam int POS_W          = 3;
   localparam int ACC_W          = FIELD_W + BYTE_W;
   localparam int LEFT_W         = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = QPTR_W + 1;

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_ALIGN  = 1'b1
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [FIELD_W-1:0]   value;
      logic [COUNT_W-1:0]   bit_count;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte;
      logic                 last;
   } rsp_type;

   // A classified item: field bits left-justified, clamped bit count.
   typedef struct packed {
      logic                 align;
      logic [COUNT_W-1:0]   bits;
      logic [FIELD_W-1:0]   field;
   } cmd_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
   } queue_stat_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EMIT = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length fields MSB first into a byte stream.
// ----------------------------------------------------------------------------
//   Channel   Direction   Beat                       Handshake
//   req_      in          operation, value, count    req_valid / req_ready
//   rsp_      out         out_byte, last             rsp_valid / rsp_ready
//
// The back unit first merges an item with the partial byte, then sends each
// completed byte out of its shift register, one byte per cycle while the
// output register is free to take it.
// Reset clears the queue, the partial byte, the bit position and rsp_valid.
// While rsp_ready is low the output register holds; the two-entry queue
// keeps taking request beats until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_packer import msbbp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   queue_stat_type   q_stat;
   cmd_type          front_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;

   msbbp_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .cmd       (front_cmd)
   );

   msbbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   msbbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/msbbp_front.sv
// ----------------------------------------------------------------------------
// msbbp_front
// Accepts request beats, clamps the bit count and left-justifies the field.
// ----------------------------------------------------------------------------
`default_nettype none

module msbbp_front import msbbp_pkg::*; (
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_data,
   input  wire queue_stat_type q_stat,
   output logic                push,
   output cmd_type             cmd
);

   logic [COUNT_W-1:0] clamped;
   logic [COUNT_W-1:0] shamt;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      if (req_data.bit_count > COUNT_W'(MAX_FIELD_BITS)) begin
         clamped = COUNT_W'(MAX_FIELD_BITS);
      end else begin
         clamped = req_data.bit_count;
      end
      shamt = COUNT_W'(FIELD_W) - clamped;

      cmd.align = (req_data.operation == OP_ALIGN);
      if (cmd.align) begin
         cmd.bits  = '0;
         cmd.field = '0;
      end else begin
         // Shifting left drops the value bits above the count.
         cmd.bits  = clamped;
         cmd.field = req_data.value << shamt;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/msbbp_queue.sv
// ----------------------------------------------------------------------------
// msbbp_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module msbbp_queue import msbbp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire cmd_type        push_cmd,
   input  wire logic           pop,
   output cmd_type             head_cmd,
   output queue_stat_type      q_stat
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign q_stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/msbbp_back.sv
// ----------------------------------------------------------------------------
// msbbp_back
// Merges commands into the partial byte and sends completed bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

module msbbp_back import msbbp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cmd_type        cmd,
   input  wire queue_stat_type q_stat,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_data
);

   back_state_type      state_ff, state_in;
   logic [BYTE_W-1:0]   partial_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [LEFT_W-1:0]   left_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic [POS_W-1:0]    pad;
   logic [COUNT_W-1:0]  n_eff;
   logic [COUNT_W-1:0]  total;
   logic [LEFT_W-1:0]   nbytes;
   logic [ACC_W-1:0]    acc_new;
   logic [ACC_W-1:0]    acc_rem;
   logic                out_free;
   logic                emit;

   // An align is an append of zero bits up to the next byte boundary.
   always_comb begin
      pad     = POS_W'(0) - pos_ff;
      n_eff   = cmd.align ? COUNT_W'(pad) : cmd.bits;
      total   = COUNT_W'(pos_ff) + n_eff;
      nbytes  = total[COUNT_W-1:POS_W];
      acc_new = {partial_ff, {FIELD_W{1'b0}}} | ({cmd.field, {BYTE_W{1'b0}}} >> pos_ff);
      acc_rem = acc_new << {nbytes, {POS_W{1'b0}}};
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty && (nbytes != '0)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free && (left_ff == LEFT_W'(1))) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop  = !q_stat.empty;
         BK_EMIT: emit = out_free;
         default: begin
            pop  = 1'b0;
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         partial_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            partial_ff <= acc_rem[ACC_W-1 -: BYTE_W];
            pos_ff     <= total[POS_W-1:0];
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         acc_ff  <= acc_new;
         left_ff <= nbytes;
      end else if (emit) begin
         acc_ff  <= acc_ff << BYTE_W;
         left_ff <= left_ff - 1'b1;
      end
      if (emit) begin
         rsp_data_ff.out_byte <= acc_ff[ACC_W-1 -: BYTE_W];
         rsp_data_ff.last     <= (left_ff == LEFT_W'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/msbbp_checker.sv
// ----------------------------------------------------------------------------
// msbbp_checker
// Port-level checks on the result channel of the bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msbbp_checker import msbbp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data
);

   logic [LEFT_W-1:0] run_ff, run_in;
   logic              rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // Counts beats since the last one that closed an item.
   always_comb begin
      run_in = run_ff;
      if (rsp_fire) begin
         run_in = rsp_data.last ? '0 : run_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   `CHK_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid, "rsp_valid high after reset")
   `CHK_ASSERT(a_hold_valid, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped")
   `CHK_ASSERT(a_hold_data, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp_data changed")
   `CHK_ASSERT(a_max_bytes, clock, reset, rsp_fire && !rsp_data.last |-> run_ff < LEFT_W'(3), "item too long")

endmodule

bind msb_first_bit_packer msbbp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for msb_first_bit_packer. A directed table of append and align
// items runs first, followed by random items sent in bursts with gaps while
// the byte sink stalls on its own pattern. Every byte from the block is compared
// with the byte that a typed row lists or that the packing model in this file predicts.
// ----------------------------------------------------------------------------

module tb_top;
   import msbbp_pkg::*;

   localparam int RANDOM_ITEMS = 410;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PAUSE_ITEM   = 150;

   typedef struct {
      req_type     req;
      bit          typed;
      int          n_exp;
      logic [31:0] exp_bytes;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Packing model state: bits placed so far, from bit 7 down, and their count.
   logic [7:0]   stream_byte = '0;
   int           stream_pos  = 0;
   rsp_type      expected_bytes[$];
   stim_row_type stim_rows[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           burst_left  = 0;
   bit           steady_send = 1'b0;

   msb_first_bit_packer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Returns the bytes that one item completes and advances the stream.
   function automatic int pack_item(input req_type item, output rsp_type outb[4]);
      int nb;
      int n;
      nb = 0;
      for (int k = 0; k < 4; k++) outb[k] = '0;
      if (item.operation == OP_ALIGN) begin
         if (stream_pos != 0) begin
            outb[0].out_byte = stream_byte;
            outb[0].last     = 1'b1;
            nb               = 1;
            stream_byte      = '0;
            stream_pos       = 0;
         end
         return nb;
      end
      n = (item.bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(item.bit_count);
      for (int i = n - 1; i >= 0; i--) begin
         stream_byte[7 - stream_pos] = item.value[i];
         stream_pos++;
         if (stream_pos == 8) begin
            outb[nb].out_byte = stream_byte;
            outb[nb].last     = 1'b0;
            nb++;
            stream_byte = '0;
            stream_pos  = 0;
         end
      end
      if (nb > 0) outb[nb - 1].last = 1'b1;
      return nb;
   endfunction

   task automatic add_row(input op_type op, input logic [31:0] value, input int count,
                          input bit typed, input int n_exp, input logic [31:0] exp_bytes);
      stim_row_type row;
      row.req.operation = op;
      row.req.value     = value;
      row.req.bit_count = COUNT_W'(count);
      row.typed         = typed;
      row.n_exp         = n_exp;
      row.exp_bytes     = exp_bytes;
      stim_rows.push_back(row);
   endtask

   // Typed rows list their bytes left-justified in exp_bytes, first byte on top.
   task automatic send_item(input req_type item, input bit typed, input int n_exp,
                            input logic [31:0] exp_bytes);
      rsp_type outb[4];
      int      nb;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      nb = pack_item(item, outb);
      if (typed) begin
         nb = n_exp;
         for (int k = 0; k < n_exp; k++) begin
            outb[k].out_byte = exp_bytes[31 - 8 * k -: 8];
            outb[k].last     = (k == n_exp - 1);
         end
      end
      for (int k = 0; k < nb; k++) expected_bytes.push_back(outb[k]);
   endtask

   task automatic pace_sender(input bit drain_first);
      int gap;
      if (drain_first) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (expected_bytes.size() != 0);
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 12);
         gap        = steady_send ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic req_type random_item();
      req_type item;
      int      pick;
      item.operation = ($urandom_range(0, 7) == 0) ? OP_ALIGN : OP_APPEND;
      item.value     = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom;
      pick = $urandom_range(0, 9);
      case (pick)
         0: item.bit_count = '0;
         1: item.bit_count = COUNT_W'(32);
         2: item.bit_count = COUNT_W'($urandom_range(33, 63));
         3, 4, 5: item.bit_count = COUNT_W'($urandom_range(1, 8));
         default: item.bit_count = COUNT_W'($urandom_range(1, 31));
      endcase
      return item;
   endfunction

   // Byte sink: alternating ready and stall runs, with an occasional long ready run.
   always @(posedge clock) begin : sink_pattern
      int  run_left;
      bit  stalling;
      if (run_left > 0) begin
         run_left--;
      end else begin
         stalling = !stalling;
         if (stalling) run_left = $urandom_range(0, 7);
         else if ($urandom_range(0, 3) == 0) run_left = 40;
         else run_left = $urandom_range(0, 14);
      end
      rsp_ready <= !stalling;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected beat: out_byte %h last %b", rsp_data.out_byte, rsp_data.last);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, actual %h", want.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_type item;
      // Extremes, zero length, oversized counts, value bits above the count,
      // and alignment both on and off a byte boundary.
      add_row(OP_APPEND, 32'h0000_00A5,  8, 1, 1, 32'hA500_0000);
      add_row(OP_APPEND, 32'hFFFF_FFFF, 32, 1, 4, 32'hFFFF_FFFF);
      add_row(OP_APPEND, 32'h0000_0000, 32, 1, 4, 32'h0000_0000);
      add_row(OP_APPEND, 32'hFFFF_FFFF,  0, 1, 0, 32'h0);
      add_row(OP_ALIGN,  32'hFFFF_FFFF, 63, 1, 0, 32'h0);
      add_row(OP_APPEND, 32'h0000_0001,  1, 1, 0, 32'h0);
      add_row(OP_ALIGN,  32'h0000_0000,  0, 1, 1, 32'h8000_0000);
      add_row(OP_APPEND, 32'h0000_0005,  3, 1, 0, 32'h0);
      add_row(OP_APPEND, 32'hDEAD_BEEF, 63, 0, 0, 32'h0);
      add_row(OP_APPEND, 32'h1234_5678, 40, 0, 0, 32'h0);
      add_row(OP_APPEND, 32'h8765_4321, 33, 0, 0, 32'h0);
      add_row(OP_ALIGN,  32'h0000_0000, 32, 0, 0, 32'h0);
      add_row(OP_APPEND, 32'h0000_007F,  7, 1, 0, 32'h0);
      add_row(OP_APPEND, 32'hFFFF_FFFE,  1, 1, 1, 32'hFE00_0000);
      add_row(OP_APPEND, 32'hFFFF_FE01,  9, 1, 1, 32'h0000_0000);
      add_row(OP_ALIGN,  32'h5555_5555,  5, 1, 1, 32'h8000_0000);
      add_row(OP_APPEND, 32'h8000_0000, 31, 1, 3, 32'h0000_0000);
      add_row(OP_ALIGN,  32'h0000_0000,  0, 1, 1, 32'h0000_0000);
      add_row(OP_APPEND, 32'h8000_0001, 32, 1, 4, 32'h8000_0001);
      add_row(OP_APPEND, 32'h0000_0015,  5, 1, 0, 32'h0);
      add_row(OP_APPEND, 32'h0F0F_0F0F, 32, 0, 0, 32'h0);
      add_row(OP_APPEND, 32'hAAAA_AA3F,  6, 0, 0, 32'h0);
      add_row(OP_ALIGN,  32'h0000_0000,  0, 0, 0, 32'h0);

      wait (!reset);
      @(posedge clock);
      foreach (stim_rows[r]) begin
         send_item(stim_rows[r].req, stim_rows[r].typed, stim_rows[r].n_exp,
                   stim_rows[r].exp_bytes);
         pace_sender(1'b0);
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         steady_send = (k >= 220 && k < 290);
         item = random_item();
         send_item(item, 1'b0, 0, 32'h0);
         if (k != RANDOM_ITEMS - 1) pace_sender(k == PAUSE_ITEM);
      end
      req_valid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
